// File: hdl/lse_pkg.sv
// ============================================================================
// lse_pkg - shared definitions for the Legendre series evaluator
// Field widths, fixed-point constants, result type and width helpers.
// ============================================================================
package lse_pkg;

  localparam int MAX_TERMS_DEF = 64;

  localparam int TC_W   = 7;   // term count register
  localparam int IDX_W  = 6;   // coefficient slot
  localparam int COEF_W = 16;  // coefficient, Q2.14
  localparam int MU_W   = 16;  // evaluation point, Q2.14
  localparam int P_W    = 32;  // P_l, Q2.30
  localparam int RES_W  = 32;  // series value, Q16.16

  localparam int X_FRAC     = 14;    // fraction bits of x
  localparam int TERM_SHIFT = 29;    // /2 and Q.44 -> Q16.16
  localparam int DIV_STEP   = 8;     // quotient bits per divider cycle
  localparam int HALF_Q16   = 32768; // 0.5 in Q16.16

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  typedef struct packed {
    logic signed [RES_W-1:0] value;
    logic                    overflow;
  } lse_result_t;

  // width of the term counter l (holds max_terms itself)
  function automatic int lw_f(input int max_terms);
    return $clog2(max_terms + 1);
  endfunction

  // coefficient table address width
  function automatic int aw_f(input int max_terms);
    return (max_terms > 1) ? $clog2(max_terms) : 1;
  endfunction

  // recurrence numerator width, signed
  function automatic int num_w_f(input int max_terms);
    return MU_W + P_W + lw_f(max_terms) + 2;
  endfunction

  // divider dividend width, rounded up to whole digits
  function automatic int qd_w_f(input int max_terms);
    return ((num_w_f(max_terms) - X_FRAC + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
  endfunction

  // weighted term width, signed
  function automatic int term_w_f(input int max_terms);
    return COEF_W + P_W + lw_f(max_terms) + 2;
  endfunction

  // accumulator width, signed
  function automatic int acc_w_f(input int max_terms);
    return term_w_f(max_terms) - TERM_SHIFT + lw_f(max_terms) + 1;
  endfunction

endpackage

// File: hdl/lse_coef_ram.sv
// ============================================================================
// lse_coef_ram - coefficient table
// One write port, one read port with registered read data.
// ============================================================================
module lse_coef_ram
  import lse_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [aw_f(MAX_TERMS)-1:0] waddr_i,
  input  logic signed [COEF_W-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [aw_f(MAX_TERMS)-1:0] raddr_i,
  output logic signed [COEF_W-1:0] rdata_o
);

  logic signed [COEF_W-1:0] mem_q [MAX_TERMS];
  logic signed [COEF_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/lse_div.sv
// ============================================================================
// lse_div - iterative unsigned divider
// Restoring division, DIV_STEP quotient bits per cycle, small divisor.
// ============================================================================
module lse_div
  import lse_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [qd_w_f(MAX_TERMS)-1:0] dividend_i,
  input  logic [lw_f(MAX_TERMS)-1:0]   divisor_i,
  output logic                        done_o,
  output logic [qd_w_f(MAX_TERMS)-1:0] quotient_o
);

  localparam int LW    = lw_f(MAX_TERMS);
  localparam int QD_W  = qd_w_f(MAX_TERMS);
  localparam int STEPS = QD_W / DIV_STEP;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [QD_W-1:0]  sh_q, sh_d;
  logic [LW-1:0]    rem_q, rem_d, dvs_q;
  logic [LW:0]      r_ext;

  // dividend shifts out at the top, quotient bits shift in at the bottom
  always_comb begin
    rem_d = rem_q;
    sh_d  = sh_q;
    r_ext = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      r_ext = {rem_d, sh_d[QD_W-1]};
      sh_d  = {sh_d[QD_W-2:0], 1'b0};
      if (r_ext >= {1'b0, dvs_q}) begin
        r_ext   = r_ext - {1'b0, dvs_q};
        sh_d[0] = 1'b1;
      end
      rem_d = r_ext[LW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // last digit lands this cycle
      done_q <= busy_q && !start_i && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(STEPS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      sh_q  <= sh_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = sh_q;

endmodule

// File: hdl/lse_core.sv
// ============================================================================
// lse_core - series evaluation sequencer
// Steps Bonnet's recurrence one term at a time and accumulates the series.
// ============================================================================
module lse_core
  import lse_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [MU_W-1:0]      mu_i,
  input  logic [TC_W-1:0]             tc_i,
  output logic                        busy_o,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output lse_result_t                 res_o,
  output logic                        rd_en_o,
  output logic [aw_f(MAX_TERMS)-1:0]  rd_addr_o,
  input  logic signed [COEF_W-1:0]    rd_data_i
);

  localparam int LW     = lw_f(MAX_TERMS);
  localparam int AW     = aw_f(MAX_TERMS);
  localparam int NUM_W  = num_w_f(MAX_TERMS);
  localparam int QD_W   = qd_w_f(MAX_TERMS);
  localparam int TERM_W = term_w_f(MAX_TERMS);
  localparam int ACC_W  = acc_w_f(MAX_TERMS);
  localparam int M1_W   = MU_W + P_W;
  localparam int M3_W   = P_W + LW + 1;
  localparam int T1_W   = COEF_W + P_W;

  localparam logic signed [P_W-1:0] P_ONE = 32'sh4000_0000;
  localparam logic signed [P_W-1:0] P_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [P_W-1:0] P_MIN = 32'sh8000_0000;
  localparam logic signed [TERM_W-1:0] T_BIAS =
    {{(TERM_W-TERM_SHIFT){1'b0}}, {TERM_SHIFT{1'b1}}};

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_NUM, S_DIVST, S_DIV,
    S_TM1, S_TM2, S_SHF, S_ACC, S_SAT, S_DONE
  } state_e;

  state_e  state_q;
  logic [LW-1:0] l_q, nl_q, nl_d, lm1_u;
  logic [LW:0]   odd_u;
  logic signed [LW+1:0] odd_s, odd2_s;
  logic signed [LW:0]   lm1_s;

  logic signed [MU_W-1:0]   x_q;
  logic signed [P_W-1:0]    p_prev_q, p_cur_q, p_new;
  logic signed [M1_W-1:0]   m1_q;
  logic signed [NUM_W-1:0]  m2_q, num_q, num_abs;
  logic signed [M3_W-1:0]   m3_q;
  logic                     neg_q;
  logic signed [T1_W-1:0]   t1_q;
  logic signed [TERM_W-1:0] t2_q, t_bias;
  logic signed [ACC_W-1:0]  sh_q, acc_q;
  logic signed [63:0]       acc_x;
  lse_result_t              res_q, res_d;

  logic            div_start, div_done;
  logic [QD_W-1:0] div_dvd, div_quo;
  logic [63:0]     q64;

  // term count above the table depth is clamped
  always_comb begin
    if (int'(tc_i) > MAX_TERMS) begin
      nl_d = LW'(MAX_TERMS);
    end else begin
      nl_d = LW'(tc_i);
    end
  end

  assign lm1_u  = l_q - LW'(1);
  assign lm1_s  = $signed({1'b0, lm1_u});
  assign odd_u  = {l_q, 1'b0} - (LW+1)'(1);
  assign odd_s  = $signed({1'b0, odd_u});
  assign odd2_s = $signed({1'b0, l_q, 1'b1});

  // magnitude of numerator, scaled by 2^-14 before the divide by l
  assign num_abs   = num_q[NUM_W-1] ? -num_q : num_q;
  assign div_dvd   = QD_W'(num_abs[NUM_W-1:X_FRAC]);
  assign div_start = (state_q == S_DIVST);

  lse_div #(
    .MAX_TERMS (MAX_TERMS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (l_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // signed, saturated P_l from quotient magnitude
  assign q64 = 64'(div_quo);
  always_comb begin
    if (!neg_q) begin
      p_new = (q64 > 64'h7FFF_FFFF) ? P_MAX : $signed(div_quo[P_W-1:0]);
    end else begin
      p_new = (q64 > 64'h8000_0000) ? P_MIN : -$signed(div_quo[P_W-1:0]);
    end
  end

  // truncate toward zero on the /2^29
  assign t_bias = t2_q[TERM_W-1] ? (t2_q + T_BIAS) : t2_q;

  assign acc_x = 64'(acc_q);
  always_comb begin
    if (acc_x > 64'sh0000_0000_7FFF_FFFF) begin
      res_d.value    = P_MAX;
      res_d.overflow = 1'b1;
    end else if (acc_x < 64'shFFFF_FFFF_8000_0000) begin
      res_d.value    = P_MIN;
      res_d.overflow = 1'b1;
    end else begin
      res_d.value    = acc_x[RES_W-1:0];
      res_d.overflow = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      l_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            l_q     <= LW'(1);
            state_q <= (nl_d == '0) ? S_SAT : S_MUL1;
          end
        end
        S_MUL1:  state_q <= S_MUL2;
        S_MUL2:  state_q <= S_MUL3;
        S_MUL3:  state_q <= S_NUM;
        S_NUM:   state_q <= S_DIVST;
        S_DIVST: state_q <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state_q <= S_TM1;
          end
        end
        S_TM1:   state_q <= S_TM2;
        S_TM2:   state_q <= S_SHF;
        S_SHF:   state_q <= S_ACC;
        S_ACC: begin
          if (l_q == nl_q) begin
            state_q <= S_SAT;
          end else begin
            l_q     <= l_q + LW'(1);
            state_q <= S_MUL1;
          end
        end
        S_SAT:   state_q <= S_DONE;
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          x_q      <= mu_i;
          nl_q     <= nl_d;
          p_prev_q <= '0;
          p_cur_q  <= P_ONE;
          acc_q    <= ACC_W'(HALF_Q16);
        end
      end
      S_MUL1:  m1_q  <= x_q * p_cur_q;
      S_MUL2:  m2_q  <= m1_q * odd_s;
      S_MUL3:  m3_q  <= p_prev_q * lm1_s;
      S_NUM:   num_q <= m2_q - (NUM_W'(m3_q) <<< X_FRAC);
      S_DIVST: neg_q <= num_q[NUM_W-1];
      S_DIV: begin
        if (div_done) begin
          p_prev_q <= p_cur_q;
          p_cur_q  <= p_new;
        end
      end
      S_TM1:   t1_q  <= p_cur_q * rd_data_i;
      S_TM2:   t2_q  <= t1_q * odd2_s;
      S_SHF:   sh_q  <= ACC_W'(t_bias >>> TERM_SHIFT);
      S_ACC:   acc_q <= acc_q + sh_q;
      S_SAT:   res_q <= res_d;
      default: ;
    endcase
  end

  // coefficient a_l is fetched early; read data holds until TM1
  assign rd_en_o     = (state_q == S_MUL1);
  assign rd_addr_o   = AW'(lm1_u);
  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

// File: hdl/legendre_series_evaluator.sv
// ============================================================================
// legendre_series_evaluator - normalized Legendre series evaluator
// Coefficient table plus a term-serial evaluator of f(x) in Q16.16.
// ============================================================================
// A coefficient write (action 0) stores a_l into slot coef_index; slots at
// or above MAX_TERMS are dropped. An evaluate item (action 1) runs over NL
// terms, where NL is term_count clamped to MAX_TERMS; the recurrence divide
// works in 8-bit quotient digits, 6 of them at the default MAX_TERMS = 64.
// The sequencer runs one term at a time through a multiplier chain, a read
// of the coefficient table and the iterative divide by l. One item is in
// work at a time: in_stall_o is high from the transfer of an evaluate item
// until its result moves into the output register, which then holds it for
// the downstream side while new items are taken. The coefficient table has
// no reset and no clearing pass; evaluate only over slots already written.
// term_count resets to 0 (f = 0.5); the user must write it only while idle,
// which the block itself does not enforce.
module legendre_series_evaluator
  import lse_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [TC_W-1:0]          cfg_wdata_i,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     action_i,
  input  logic [IDX_W-1:0]         coef_index_i,
  input  logic signed [COEF_W-1:0] coef_value_i,
  input  logic signed [MU_W-1:0]   mu_value_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [RES_W-1:0]  series_value_o,
  output logic                     overflow_o
);

  localparam int AW = aw_f(MAX_TERMS);

  logic [TC_W-1:0] term_count_q;

  logic            in_xfer;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_raddr;
  logic signed [COEF_W-1:0] ram_rdata;

  logic            core_start, core_busy, core_res_valid, res_take;
  lse_result_t     core_res;

  logic            out_valid_q;
  lse_result_t     out_q;

  // term count register; the user must keep it written only while idle, which is not enforced here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_count_q <= '0;
    end else if (cfg_we_i) begin
      term_count_q <= cfg_wdata_i;
    end
  end

  // an item is taken whenever the sequencer is free
  assign in_stall_o = core_busy;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign core_start = in_xfer && (action_i == ACT_EVAL);
  assign ram_we     = in_xfer && (action_i == ACT_WRITE) &&
                      (int'(coef_index_i) < MAX_TERMS);

  // writes and evaluation never overlap, so no forwarding is needed
  lse_coef_ram #(
    .MAX_TERMS (MAX_TERMS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(coef_index_i)),
    .wdata_i (coef_value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lse_core #(
    .MAX_TERMS (MAX_TERMS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (core_start),
    .mu_i        (mu_value_i),
    .tc_i        (term_count_q),
    .busy_o      (core_busy),
    .res_valid_o (core_res_valid),
    .res_ready_i (res_take),
    .res_o       (core_res),
    .rd_en_o     (ram_re),
    .rd_addr_o   (ram_raddr),
    .rd_data_i   (ram_rdata)
  );

  // output register: loads when empty or when its contents transfer
  assign res_take = core_res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= core_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign series_value_o = out_q.value;
  assign overflow_o     = out_q.overflow;

`ifndef SYNTH
  // evaluate transfer must lock out the input side
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_start |=> core_busy)
    else $error("evaluate transfer did not start the sequencer");

  // a handed-off result is never offered twice
  a_handoff_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |=> (!core_res_valid && out_valid_q))
    else $error("result handoff repeated or lost");

  // overflow only with a saturated value
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |->
      (series_value_o == 32'sh7FFF_FFFF || series_value_o == 32'sh8000_0000))
    else $error("overflow flagged on an unsaturated value");
`endif

endmodule
